@@ src/lecf_pkg.sv @@
// lecf_pkg: shared types and constants of the lift encoder count filter
// used by lecf_filter, lecf_scale and the top level; no dependencies
`timescale 1ns / 1ps

package lecf_pkg;

	localparam int CNT_W  = 16;
	localparam int TGT_W  = 11;
	localparam int CUR_W  = 12;
	localparam int STL_W  = 7;
	localparam int BCK_W  = 8;
	localparam int H_W    = 12;
	localparam int HF_W   = 15;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 16;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_HOME_COUNT   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_TOP_COUNT    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_TOP_TARGET   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_STALL_LIMIT  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_JUMP_LIMIT   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_BACKSTEP     = 3'd5;
	localparam logic [CIDX_W-1:0] REG_HEIGHT_SCALE = 3'd6;
	localparam logic [CIDX_W-1:0] REG_MM_SCALE     = 3'd7;

	// reset values of the configuration registers
	localparam logic [CNT_W-1:0] RST_HOME_COUNT   = 16'd1000;
	localparam logic [CNT_W-1:0] RST_TOP_COUNT    = 16'd4260;
	localparam logic [TGT_W-1:0] RST_TOP_TARGET   = 11'd70;
	localparam logic [STL_W-1:0] RST_STALL_LIMIT  = 7'd100;
	localparam logic [CNT_W-1:0] RST_JUMP_LIMIT   = 16'd20;
	localparam logic [BCK_W-1:0] RST_BACKSTEP     = 8'd3;
	localparam logic [CNT_W-1:0] RST_HEIGHT_SCALE = 16'd1409;
	localparam logic [CNT_W-1:0] RST_MM_SCALE     = 16'd13959;

	typedef struct packed {
		logic [CNT_W-1:0] home_count;
		logic [CNT_W-1:0] top_count;
		logic [TGT_W-1:0] top_target;
		logic [STL_W-1:0] stall_limit;
		logic [CNT_W-1:0] jump_limit;
		logic [BCK_W-1:0] backstep;
		logic [CNT_W-1:0] height_scale;
		logic [CNT_W-1:0] mm_scale;
	} cfg_t;

	// result of the filter stage, handed to the scaling stage
	typedef struct packed {
		logic [CNT_W-1:0] filt;
		logic             wr;
		logic [CNT_W-1:0] wval;
		logic             ok;
		logic             d_neg;
		logic [CNT_W-1:0] d_mag;
	} filt_res_t;

endpackage

@@ src/lecf_filter.sv @@
// lecf_filter: stall, jump and backward-step filter with the count state
// depends on lecf_pkg
`timescale 1ns / 1ps

module lecf_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lecf_pkg::cfg_t            cfg,
	input  logic                      adv,
	input  logic [lecf_pkg::CNT_W-1:0] raw_count,
	input  logic [lecf_pkg::TGT_W-1:0] target_height,
	input  logic signed [lecf_pkg::CUR_W-1:0] current_height,
	output lecf_pkg::filt_res_t       res
);
	import lecf_pkg::*;

	logic [CNT_W-1:0] last_count_q, last_d;
	logic [STL_W-1:0] stall_q, stall_d;

	logic             same;
	logic [STL_W-1:0] c1, c2;
	logic signed [CNT_W:0] diff;
	logic [CNT_W-1:0] adiff;
	logic             rising;
	logic [CNT_W:0]   bsum;
	logic [CNT_W-1:0] bsat;
	logic [CNT_W:0]   dd;

	always_comb begin
		same   = (raw_count == last_count_q);
		diff   = $signed({1'b0, raw_count}) - $signed({1'b0, last_count_q});
		adiff  = diff[CNT_W] ? CNT_W'(-diff) : diff[CNT_W-1:0];
		rising = $signed({current_height[CUR_W-1], current_height})
			< $signed({2'b00, target_height});
		bsum   = {1'b0, last_count_q} + {{(CNT_W+1-BCK_W){1'b0}}, cfg.backstep};
		bsat   = bsum[CNT_W] ? {CNT_W{1'b1}} : bsum[CNT_W-1:0];

		res.filt = raw_count;
		res.wr   = 1'b0;
		res.wval = '0;
		res.ok   = 1'b0;
		last_d   = last_count_q;
		stall_d  = stall_q;
		c1       = stall_q;
		c2       = stall_q;

		if (same) begin
			// stalled at home target
			if (target_height == '0) begin
				c1 = stall_q + 1'b1;
				if (c1 >= cfg.stall_limit) begin
					res.filt = cfg.home_count;
					last_d   = cfg.home_count;
					res.wr   = 1'b1;
					res.wval = cfg.home_count;
					c1       = '0;
				end
			end
			// stalled at top target, sees the home step's counter
			c2 = c1;
			if (target_height == cfg.top_target) begin
				c2 = c1 + 1'b1;
				if (c2 >= cfg.stall_limit) begin
					res.filt = cfg.top_count;
					last_d   = cfg.top_count;
					res.wr   = 1'b1;
					res.wval = cfg.top_count;
					res.ok   = 1'b1;
					c2       = '0;
				end
			end
			stall_d = c2;
		end else begin
			stall_d = '0;
			if (adiff > cfg.jump_limit) begin
				res.filt = last_count_q;
				res.wr   = 1'b1;
				res.wval = last_count_q;
			end else if (rising && diff[CNT_W]) begin
				res.filt = bsat;
				res.wr   = 1'b1;
				res.wval = bsat;
			end else begin
				last_d = raw_count;
			end
			// clamp request below home
			if (res.filt < cfg.home_count) begin
				res.wr   = 1'b1;
				res.wval = cfg.home_count;
			end
		end

		dd        = {1'b0, res.filt} - {1'b0, cfg.home_count};
		res.d_neg = dd[CNT_W];
		res.d_mag = dd[CNT_W] ? CNT_W'(-dd) : dd[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= RST_HOME_COUNT;
			stall_q      <= '0;
		end else if (adv) begin
			last_count_q <= last_d;
			stall_q      <= stall_d;
		end
	end

endmodule

@@ src/lecf_scale.sv @@
// lecf_scale: signed Q16 scaling with truncation toward zero and saturation
// depends on lecf_pkg
`timescale 1ns / 1ps

module lecf_scale #(
	parameter int OUT_W = 12
) (
	input  logic                        d_neg,
	input  logic [lecf_pkg::CNT_W-1:0]  d_mag,
	input  logic [lecf_pkg::CNT_W-1:0]  k,
	output logic signed [OUT_W-1:0]     y
);
	import lecf_pkg::*;

	localparam logic [CNT_W-1:0] MAXP = CNT_W'((1 << (OUT_W - 1)) - 1);

	logic [2*CNT_W-1:0] prod;
	logic [CNT_W-1:0]   m;
	logic [OUT_W-1:0]   sat_m;

	always_comb begin
		prod = d_mag * k;
		m    = prod[2*CNT_W-1:CNT_W];
		// negative side reaches one step further
		if (!d_neg) sat_m = (m > MAXP) ? OUT_W'(MAXP) : OUT_W'(m);
		else sat_m = (m > MAXP + 1'b1) ? OUT_W'(MAXP + 1'b1) : OUT_W'(m);
		y = d_neg ? $signed(-sat_m) : $signed(sat_m);
	end

endmodule

@@ src/lift_encoder_count_filter.sv @@
// lift_encoder_count_filter: top level, config registers and pipeline
// depends on lecf_pkg, lecf_filter, lecf_scale
`timescale 1ns / 1ps

// usage
// input channel: in_valid/in_ready carry one counter sample per item
//   (raw_count, target_height, current_height)
// output channel: out_valid/out_ready carry one result item per sample
//   (filtered_count, write_counter, write_value, height, height_fine, lift_ok)
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high; user writes only while no item is in flight, not enforced
// pipeline: input register, filter stage register, output register
//   throughput is one item per clock while out_ready stays high, with the filter
//   state updated as an item leaves the input register
// the scaling multipliers (16x16) sit between the filter stage register
//   and the output register
// reset: config registers take their defaults, last count becomes 1000,
//   stall counter clears, pipeline empties
// receiver stall: the output register holds its item, the stages behind
//   fill up, then in_ready drops; no item is lost or repeated

module lift_encoder_count_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lecf_pkg::CNT_W-1:0]        raw_count,
	input  logic [lecf_pkg::TGT_W-1:0]        target_height,
	input  logic signed [lecf_pkg::CUR_W-1:0] current_height,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lecf_pkg::CNT_W-1:0]        filtered_count,
	output logic                              write_counter,
	output logic [lecf_pkg::CNT_W-1:0]        write_value,
	output logic signed [lecf_pkg::H_W-1:0]   height,
	output logic signed [lecf_pkg::HF_W-1:0]  height_fine,
	output logic                              lift_ok,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lecf_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [lecf_pkg::CDAT_W-1:0]       cfg_data
);
	import lecf_pkg::*;

	cfg_t cfg_q;

	// input register
	logic                    v_s1;
	logic [CNT_W-1:0]        raw_s1;
	logic [TGT_W-1:0]        tgt_s1;
	logic signed [CUR_W-1:0] cur_s1;

	// filter stage register
	logic      v_s2;
	filt_res_t res_s2;
	filt_res_t res_c;

	// output register
	logic                    out_valid_q;
	logic [CNT_W-1:0]        filt_q;
	logic                    wr_q;
	logic [CNT_W-1:0]        wval_q;
	logic signed [H_W-1:0]   h_q;
	logic signed [HF_W-1:0]  hf_q;
	logic                    ok_q;

	logic signed [H_W-1:0]  h_c;
	logic signed [HF_W-1:0] hf_c;

	logic ld_o, ld_s2, ld_s1, adv_s1;

	// a stage can load when it is empty or its item moves on
	assign ld_o     = !out_valid_q || out_ready;
	assign ld_s2    = !v_s2 || ld_o;
	assign ld_s1    = !v_s1 || ld_s2;
	assign adv_s1   = v_s1 && ld_s2;
	assign in_ready = ld_s1;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_count   <= RST_HOME_COUNT;
			cfg_q.top_count    <= RST_TOP_COUNT;
			cfg_q.top_target   <= RST_TOP_TARGET;
			cfg_q.stall_limit  <= RST_STALL_LIMIT;
			cfg_q.jump_limit   <= RST_JUMP_LIMIT;
			cfg_q.backstep     <= RST_BACKSTEP;
			cfg_q.height_scale <= RST_HEIGHT_SCALE;
			cfg_q.mm_scale     <= RST_MM_SCALE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HOME_COUNT:   cfg_q.home_count   <= cfg_data[CNT_W-1:0];
				REG_TOP_COUNT:    cfg_q.top_count    <= cfg_data[CNT_W-1:0];
				REG_TOP_TARGET:   cfg_q.top_target   <= cfg_data[TGT_W-1:0];
				REG_STALL_LIMIT:  cfg_q.stall_limit  <= cfg_data[STL_W-1:0];
				REG_JUMP_LIMIT:   cfg_q.jump_limit   <= cfg_data[CNT_W-1:0];
				REG_BACKSTEP:     cfg_q.backstep     <= cfg_data[BCK_W-1:0];
				REG_HEIGHT_SCALE: cfg_q.height_scale <= cfg_data[CNT_W-1:0];
				REG_MM_SCALE:     cfg_q.mm_scale     <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_o) out_valid_q <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			raw_s1 <= raw_count;
			tgt_s1 <= target_height;
			cur_s1 <= current_height;
		end
		if (adv_s1) res_s2 <= res_c;
		if (ld_o && v_s2) begin
			filt_q <= res_s2.filt;
			wr_q   <= res_s2.wr;
			wval_q <= res_s2.wr ? res_s2.wval : '0;
			h_q    <= h_c;
			hf_q   <= hf_c;
			ok_q   <= res_s2.ok;
		end
	end

	// filter with last count and stall counter, updated as the item leaves s1
	lecf_filter u_filter (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.adv            (adv_s1),
		.raw_count      (raw_s1),
		.target_height  (tgt_s1),
		.current_height (cur_s1),
		.res            (res_c)
	);

	lecf_scale #(.OUT_W(H_W)) u_scale_h (
		.d_neg (res_s2.d_neg),
		.d_mag (res_s2.d_mag),
		.k     (cfg_q.height_scale),
		.y     (h_c)
	);

	lecf_scale #(.OUT_W(HF_W)) u_scale_hf (
		.d_neg (res_s2.d_neg),
		.d_mag (res_s2.d_mag),
		.k     (cfg_q.mm_scale),
		.y     (hf_c)
	);

	assign out_valid      = out_valid_q;
	assign filtered_count = filt_q;
	assign write_counter  = wr_q;
	assign write_value    = wval_q;
	assign height         = h_q;
	assign height_fine    = hf_q;
	assign lift_ok        = ok_q;

endmodule

@@ src/lecf_checker.sv @@
// lecf_checker: port-level assertions for the lift encoder count filter
// depends on lecf_pkg; bound to lift_encoder_count_filter
`timescale 1ns / 1ps

module lecf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [lecf_pkg::CNT_W-1:0]        filtered_count,
	input logic                              write_counter,
	input logic [lecf_pkg::CNT_W-1:0]        write_value,
	input logic                              lift_ok,
	input logic                              cfg_ready
);
	import lecf_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_count)
			&& $stable(write_value))
		else $error("result item changed while stalled");

	// input is held off only behind a stalled result item
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result item");

	// no write request means a zero write value
	a_wval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_counter |-> write_value == '0)
		else $error("write value without write request");

	// top re-home writes back the forced count
	a_lift_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lift_ok |-> write_counter && write_value == filtered_count)
		else $error("lift_ok without matching write-back");

	// config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind lift_encoder_count_filter lecf_checker u_lecf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.filtered_count (filtered_count),
	.write_counter  (write_counter),
	.write_value    (write_value),
	.lift_ok        (lift_ok),
	.cfg_ready      (cfg_ready)
);

@@ test/lift_encoder_count_filter_tb.sv @@
// lift_encoder_count_filter_tb: self-checking bench for the lift encoder count filter
// drives counter samples and register writes, predicts every result item on accept
// depends on lecf_pkg and lift_encoder_count_filter
`timescale 1ns / 1ps

module lift_encoder_count_filter_tb;
	import lecf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_MAX     = 10;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;

	// settings loaded at the start of each random phase
	localparam int SET_MODERATE = 0;
	localparam int SET_MAXIMUM  = 1;
	localparam int SET_MINIMUM  = 2;
	localparam int SET_DEFAULT  = 3;

	typedef struct packed {
		logic [CNT_W-1:0]        raw;
		logic [TGT_W-1:0]        tgt;
		logic signed [CUR_W-1:0] cur;
	} lift_sample_t;

	typedef struct packed {
		logic [CNT_W-1:0]        filtered_count;
		logic                    write_counter;
		logic [CNT_W-1:0]        write_value;
		logic signed [H_W-1:0]   height;
		logic signed [HF_W-1:0]  height_fine;
		logic                    lift_ok;
	} lift_result_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_ready;
	logic [CNT_W-1:0]         raw_count      = '0;
	logic [TGT_W-1:0]         target_height  = '0;
	logic signed [CUR_W-1:0]  current_height = '0;
	logic                     out_valid;
	logic                     out_ready      = 1'b0;
	logic [CNT_W-1:0]         filtered_count;
	logic                     write_counter;
	logic [CNT_W-1:0]         write_value;
	logic signed [H_W-1:0]    height;
	logic signed [HF_W-1:0]   height_fine;
	logic                     lift_ok;
	logic                     cfg_valid      = 1'b0;
	logic                     cfg_ready;
	logic [CIDX_W-1:0]        cfg_index      = '0;
	logic [CDAT_W-1:0]        cfg_data       = '0;

	lift_sample_t pending_samples[$];
	lift_result_t expected_results[$];

	// predictor state: its own copy of the registers, last count and stall counter
	cfg_t             shadow_cfg;
	logic [CNT_W-1:0] last_cnt;
	logic [STL_W-1:0] stall_cnt;

	logic in_fire        = 1'b0;
	int   n_queued       = 0;
	int   n_taken        = 0;
	int   cfg_writes     = 0;
	int   mismatches     = 0;
	int   idle_cycles    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_trigger   = 0;
	int   hold_seen      = 0;
	int   hold_left      = 0;
	int   gen_pos        = 0;

	lift_encoder_count_filter u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_count      (raw_count),
		.target_height  (target_height),
		.current_height (current_height),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_count (filtered_count),
		.write_counter  (write_counter),
		.write_value    (write_value),
		.height         (height),
		.height_fine    (height_fine),
		.lift_ok        (lift_ok),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int rnd(input int lo, input int hi);
		return int'($urandom_range(hi, lo));
	endfunction

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Q16 scaling of a signed count offset, truncated toward zero, then saturated
	function automatic longint apply_q16_scale(input longint d, input logic [CNT_W-1:0] k,
			input longint lo, input longint hi);
		longint v;
		v = (((d < 0) ? -d : d) * longint'(k)) >>> 16;
		if (d < 0)
			v = -v;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	task automatic predict_count_filter(input lift_sample_t s, output lift_result_t r);
		int              diff;
		int              adiff;
		logic [CNT_W:0]  bsum;
		longint          d;
		longint          hv;
		longint          hfv;
		r = '0;
		r.filtered_count = s.raw;
		if (s.raw == last_cnt) begin
			// stalled at home, then stalled at top; with top target zero both apply
			if (s.tgt == '0) begin
				stall_cnt = stall_cnt + 1'b1;
				if (stall_cnt >= shadow_cfg.stall_limit) begin
					r.filtered_count = shadow_cfg.home_count;
					r.write_counter  = 1'b1;
					r.write_value    = shadow_cfg.home_count;
					last_cnt         = shadow_cfg.home_count;
					stall_cnt        = '0;
				end
			end
			if (s.tgt == shadow_cfg.top_target) begin
				stall_cnt = stall_cnt + 1'b1;
				if (stall_cnt >= shadow_cfg.stall_limit) begin
					r.filtered_count = shadow_cfg.top_count;
					r.write_counter  = 1'b1;
					r.write_value    = shadow_cfg.top_count;
					r.lift_ok        = 1'b1;
					last_cnt         = shadow_cfg.top_count;
					stall_cnt        = '0;
				end
			end
		end else begin
			diff      = int'(s.raw) - int'(last_cnt);
			adiff     = (diff < 0) ? -diff : diff;
			stall_cnt = '0;
			if (adiff > int'(shadow_cfg.jump_limit)) begin
				// jump rejected, last count kept and written back
				r.filtered_count = last_cnt;
				r.write_counter  = 1'b1;
				r.write_value    = last_cnt;
			end else if (int'($signed(s.cur)) < int'(s.tgt) && diff < 0) begin
				// backward step while rising
				bsum             = {1'b0, last_cnt} + {{(CNT_W-BCK_W+1){1'b0}}, shadow_cfg.backstep};
				r.filtered_count = bsum[CNT_W] ? '1 : bsum[CNT_W-1:0];
				r.write_counter  = 1'b1;
				r.write_value    = r.filtered_count;
			end else begin
				last_cnt = s.raw;
			end
			if (r.filtered_count < shadow_cfg.home_count) begin
				r.write_counter = 1'b1;
				r.write_value   = shadow_cfg.home_count;
			end
		end
		d             = longint'(r.filtered_count) - longint'(shadow_cfg.home_count);
		hv            = apply_q16_scale(d, shadow_cfg.height_scale, -2048, 2047);
		hfv           = apply_q16_scale(d, shadow_cfg.mm_scale, -16384, 16383);
		r.height      = hv[H_W-1:0];
		r.height_fine = hfv[HF_W-1:0];
	endtask

	// monitor: checks result items, predicts on input accept, mirrors register writes
	always @(posedge clk) begin
		lift_result_t got;
		lift_result_t want;
		lift_result_t predicted;
		lift_sample_t s;
		logic         any_fire;
		if (!arst_n) begin
			shadow_cfg.home_count   = RST_HOME_COUNT;
			shadow_cfg.top_count    = RST_TOP_COUNT;
			shadow_cfg.top_target   = RST_TOP_TARGET;
			shadow_cfg.stall_limit  = RST_STALL_LIMIT;
			shadow_cfg.jump_limit   = RST_JUMP_LIMIT;
			shadow_cfg.backstep     = RST_BACKSTEP;
			shadow_cfg.height_scale = RST_HEIGHT_SCALE;
			shadow_cfg.mm_scale     = RST_MM_SCALE;
			last_cnt                = RST_HOME_COUNT;
			stall_cnt               = '0;
			in_fire                 = 1'b0;
		end else begin
			any_fire = 1'b0;
			if (out_valid && out_ready) begin
				any_fire            = 1'b1;
				got.filtered_count  = filtered_count;
				got.write_counter   = write_counter;
				got.write_value     = write_value;
				got.height          = height;
				got.height_fine     = height_fine;
				got.lift_ok         = lift_ok;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result item: count %0d", got.filtered_count);
				end else begin
					want = expected_results.pop_front();
					if (got.filtered_count !== want.filtered_count ||
							got.write_counter !== want.write_counter ||
							got.write_value !== want.write_value ||
							got.height !== want.height ||
							got.height_fine !== want.height_fine ||
							got.lift_ok !== want.lift_ok) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("mismatch exp: cnt %0d wr %0b val %0d h %0d hf %0d ok %0b",
								want.filtered_count, want.write_counter, want.write_value,
								$signed(want.height), $signed(want.height_fine), want.lift_ok);
							$display("         got: cnt %0d wr %0b val %0d h %0d hf %0d ok %0b",
								got.filtered_count, got.write_counter, got.write_value,
								$signed(got.height), $signed(got.height_fine), got.lift_ok);
						end
					end
				end
			end
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				any_fire = 1'b1;
				s.raw    = raw_count;
				s.tgt    = target_height;
				s.cur    = current_height;
				predict_count_filter(s, predicted);
				expected_results.push_back(predicted);
				n_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				any_fire = 1'b1;
				case (cfg_index)
					REG_HOME_COUNT:   shadow_cfg.home_count   = cfg_data;
					REG_TOP_COUNT:    shadow_cfg.top_count    = cfg_data;
					REG_TOP_TARGET:   shadow_cfg.top_target   = cfg_data[TGT_W-1:0];
					REG_STALL_LIMIT:  shadow_cfg.stall_limit  = cfg_data[STL_W-1:0];
					REG_JUMP_LIMIT:   shadow_cfg.jump_limit   = cfg_data;
					REG_BACKSTEP:     shadow_cfg.backstep     = cfg_data[BCK_W-1:0];
					REG_HEIGHT_SCALE: shadow_cfg.height_scale = cfg_data;
					REG_MM_SCALE:     shadow_cfg.mm_scale     = cfg_data;
					default: ;
				endcase
				cfg_writes++;
			end
			idle_cycles = any_fire ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// sender: presents the next pending sample once the current one is taken
	always @(negedge clk) begin
		lift_sample_t nxt;
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_samples.size() != 0 && rnd(0, 99) >= send_idle_pct) begin
				nxt            = pending_samples.pop_front();
				in_valid       <= 1'b1;
				raw_count      <= nxt.raw;
				target_height  <= nxt.tgt;
				current_height <= nxt.cur;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (rnd(0, 99) >= recv_stall_pct);
		end
	end

	task automatic add_sample(input int raw, input int tgt, input int cur);
		lift_sample_t s;
		s.raw = raw[CNT_W-1:0];
		s.tgt = tgt[TGT_W-1:0];
		s.cur = cur[CUR_W-1:0];
		pending_samples.push_back(s);
		n_queued++;
	endtask

	// called at a falling edge; leaves cfg_valid high for a following write
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
		int seen;
		seen = cfg_writes;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (cfg_writes == seen);
	endtask

	task automatic wait_idle();
		while (n_taken != n_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_settings(input int which);
		int home;
		case (which)
			SET_MODERATE: begin
				home = rnd(0, 6000);
				write_reg(REG_HOME_COUNT, 16'(home));
				write_reg(REG_TOP_COUNT, 16'(home + rnd(200, 4000)));
				// upper bits of the narrow registers are junk and must be dropped
				write_reg(REG_TOP_TARGET, {5'($urandom), 11'(rnd(1, 150))});
				write_reg(REG_STALL_LIMIT, {9'($urandom), 7'(rnd(1, 6))});
				write_reg(REG_JUMP_LIMIT, 16'(rnd(4, 60)));
				write_reg(REG_BACKSTEP, 16'($urandom));
				write_reg(REG_HEIGHT_SCALE, 16'($urandom));
				write_reg(REG_MM_SCALE, 16'($urandom));
			end
			SET_MAXIMUM: begin
				write_reg(REG_HOME_COUNT, 16'd0);
				write_reg(REG_TOP_COUNT, 16'hFFFF);
				write_reg(REG_TOP_TARGET, 16'd2047);
				write_reg(REG_STALL_LIMIT, 16'd127);
				write_reg(REG_JUMP_LIMIT, 16'hFFFF);
				write_reg(REG_BACKSTEP, 16'd255);
				write_reg(REG_HEIGHT_SCALE, 16'hFFFF);
				write_reg(REG_MM_SCALE, 16'hFFFF);
			end
			SET_MINIMUM: begin
				// top target zero: both stall tests run on every home stall
				write_reg(REG_HOME_COUNT, 16'hFFFF);
				write_reg(REG_TOP_COUNT, 16'd0);
				write_reg(REG_TOP_TARGET, 16'd0);
				write_reg(REG_STALL_LIMIT, 16'd0);
				write_reg(REG_JUMP_LIMIT, 16'd0);
				write_reg(REG_BACKSTEP, 16'd0);
				write_reg(REG_HEIGHT_SCALE, 16'd0);
				write_reg(REG_MM_SCALE, 16'd0);
			end
			default: begin
				write_reg(REG_HOME_COUNT, RST_HOME_COUNT);
				write_reg(REG_TOP_COUNT, RST_TOP_COUNT);
				write_reg(REG_TOP_TARGET, 16'(RST_TOP_TARGET));
				write_reg(REG_STALL_LIMIT, 16'(RST_STALL_LIMIT));
				write_reg(REG_JUMP_LIMIT, RST_JUMP_LIMIT);
				write_reg(REG_BACKSTEP, 16'(RST_BACKSTEP));
				write_reg(REG_HEIGHT_SCALE, RST_HEIGHT_SCALE);
				write_reg(REG_MM_SCALE, RST_MM_SCALE);
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	// lift-like traffic: small moves, stall runs at home or top, backward steps
	// while rising, rejected jumps, and a little pure noise
	task automatic gen_traffic(input int n);
		int made;
		int pick;
		int step_max;
		int tgt;
		int run;
		int top_tgt;
		made    = 0;
		gen_pos = int'(last_cnt);
		top_tgt = int'(shadow_cfg.top_target);
		while (made < n) begin
			pick     = rnd(0, 99);
			step_max = (shadow_cfg.jump_limit < 40) ? int'(shadow_cfg.jump_limit) : 40;
			if (pick < 45) begin
				run = rnd(0, 99);
				tgt = (run < 30) ? 0 : ((run < 60) ? top_tgt : rnd(0, 2047));
				repeat (rnd(3, 12)) begin
					gen_pos = clip(gen_pos + (rnd(0, 1) ? rnd(0, step_max) : -rnd(0, step_max)),
						0, 65535);
					add_sample(gen_pos, tgt,
						rnd(0, 1) ? tgt - rnd(1, 60) : clip(tgt + rnd(0, 60), 0, 2047));
					made++;
				end
			end else if (pick < 70) begin
				tgt = (rnd(0, 3) == 0) ? rnd(0, 2047) : (rnd(0, 1) ? 0 : top_tgt);
				run = int'(shadow_cfg.stall_limit) + rnd(0, 3);
				if (run < 1)
					run = 1;
				repeat (run) begin
					add_sample(gen_pos, tgt, rnd(0, 4095) - 2048);
					made++;
				end
				if (tgt == top_tgt)
					gen_pos = int'(shadow_cfg.top_count);
				else if (tgt == 0)
					gen_pos = int'(shadow_cfg.home_count);
			end else if (pick < 85) begin
				tgt = rnd(1, 2047);
				add_sample(clip(gen_pos - rnd(1, (step_max > 0) ? step_max : 1), 0, 65535),
					tgt, tgt - rnd(1, 200));
				made++;
			end else if (pick < 93) begin
				run = int'(shadow_cfg.jump_limit) + rnd(1, 500);
				add_sample(clip(gen_pos + (rnd(0, 1) ? run : -run), 0, 65535),
					rnd(0, 2047), rnd(0, 4095) - 2048);
				made++;
			end else begin
				add_sample(rnd(0, 65535), rnd(0, 2047), rnd(0, 4095) - 2048);
				made++;
			end
		end
	endtask

	initial begin
		int set_sel;
		int n_items;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, reset settings except a short stall limit
		write_reg(REG_STALL_LIMIT, 16'd2);
		cfg_valid <= 1'b0;
		add_sample(1000, 0, 0);         // stalled at home, first count
		add_sample(1000, 0, 0);         // re-home to home count
		add_sample(1010, 70, 0);        // normal move up
		add_sample(1005, 70, 0);        // backward while rising
		add_sample(1005, 70, 100);      // backward but not rising: accepted
		add_sample(1005, 70, 100);      // stalled at top
		add_sample(1005, 70, 100);      // re-home to top count, lift ok
		add_sample(4280, 70, 0);        // move of exactly the jump limit
		add_sample(4301, 70, 0);        // one over the jump limit: rejected
		add_sample(4280, 5, 0);         // stalled elsewhere
		add_sample(0, 0, -2048);        // large jump down: rejected
		add_sample(4280, 0, 0);
		add_sample(4280, 0, 0);         // back to home count
		add_sample(995, 0, 0);          // below home: home written back
		add_sample(995, 0, -5);
		add_sample(65535, 2047, 2047);
		add_sample(0, 2047, -2048);
		add_sample(65535, 0, -2048);
		add_sample(21845, 1365, -1366); // alternating bit patterns
		add_sample(43690, 682, 1365);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin set_sel = SET_MODERATE; send_idle_pct = 0;  recv_stall_pct = 0;  n_items = 250; end
				1: begin set_sel = SET_MAXIMUM;  send_idle_pct = 88; recv_stall_pct = 0;  n_items = 200; end
				2: begin set_sel = SET_MINIMUM;  send_idle_pct = 0;  recv_stall_pct = 88; n_items = 150; end
				3: begin set_sel = SET_DEFAULT;  send_idle_pct = 14; recv_stall_pct = 14; n_items = 200; end
				default: begin
					set_sel = SET_MODERATE; send_idle_pct = 14; recv_stall_pct = 14; n_items = 200;
				end
			endcase
			load_settings(set_sel);
			if (set_sel == SET_MAXIMUM) begin
				// backstep saturating at the counter top, heights saturating
				add_sample(65535, 100, -2048);
				add_sample(65534, 100, -2048);
			end
			gen_traffic(n_items);
			// sender keeps offering while the receiver holds off: the block fills
			if (ph == 0)
				hold_trigger++;
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += expected_results.size();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/lecf_pkg.sv
src/lecf_filter.sv
src/lecf_scale.sv
src/lift_encoder_count_filter.sv
src/lecf_checker.sv
test/lift_encoder_count_filter_tb.sv
